@@ rtl/meeu_pkg.sv @@
// Package for the coprocessor-0 exception entry unit.
// Holds the event kinds, vector constants and the structs shared by the core and the top level.
// No dependencies.
package meeu_pkg;

    localparam logic [31:0] STATUS_RESET     = 32'h1090_0000;
    localparam logic [31:0] VEC_RESET        = 32'hBFC0_0000;
    localparam logic [31:0] VEC_GENERAL_BEV0 = 32'h8000_0080;
    localparam logic [31:0] VEC_GENERAL_BEV1 = 32'hBFC0_0180;
    localparam logic [31:0] PC_STEP          = 32'd4;
    localparam int          BEV_BIT          = 22;
    localparam int          MODE_STACK_W     = 6;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        KIND_EXCEPTION    = 2'd0,
        KIND_ALIGN        = 2'd1,
        KIND_RESET        = 2'd2,
        KIND_STATUS_WRITE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  exc_code;
        logic [31:0] current_pc;
        logic        in_delay_slot;
        logic [31:0] access_address;
        logic        access_is_word;
        logic [31:0] write_value;
    } t_event;

    typedef struct packed {
        logic [31:0] status;
        logic [31:0] epc;
        logic [4:0]  cause;
        logic        bd;
        logic [31:0] bad_address;
    } t_cp0_state;

    typedef struct packed {
        logic        redirect;
        logic [31:0] new_pc;
        logic [31:0] next_pc;
        logic        misaligned;
    } t_result;

endpackage

@@ rtl/meeu_core.sv @@
// Next-state and result logic of the coprocessor-0 exception entry unit.
// Purely combinational; uses the types and constants of meeu_pkg.
module meeu_core (
    input  meeu_pkg::t_event     i_event,
    input  meeu_pkg::t_cp0_state i_state,
    output meeu_pkg::t_cp0_state o_state,
    output meeu_pkg::t_result    o_result
);

    logic [meeu_pkg::MODE_STACK_W-1:0] pushed_stack;
    logic [31:0]                       pushed_status;
    logic                              addr_bad;

    // The mode/interrupt-enable stack moves up one level; the new level is kernel, disabled.
    assign pushed_stack  = {i_state.status[meeu_pkg::MODE_STACK_W-3:0], 2'b00};
    assign pushed_status = {i_state.status[31:meeu_pkg::MODE_STACK_W], pushed_stack};
    assign addr_bad      = i_event.access_is_word ? (i_event.access_address[1:0] != 2'b00)
                                                  : i_event.access_address[0];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_event.kind)
            meeu_pkg::KIND_EXCEPTION: begin
                o_state.status = pushed_status;
                o_state.bd     = i_event.in_delay_slot;
                o_state.epc    = i_event.in_delay_slot ? (i_event.current_pc - meeu_pkg::PC_STEP)
                                                       : i_event.current_pc;
                o_state.cause  = i_event.exc_code;
                o_result.redirect = 1'b1;
                o_result.new_pc   = pushed_status[meeu_pkg::BEV_BIT]
                                    ? meeu_pkg::VEC_GENERAL_BEV1 : meeu_pkg::VEC_GENERAL_BEV0;
                o_result.next_pc  = pushed_status[meeu_pkg::BEV_BIT]
                                    ? (meeu_pkg::VEC_GENERAL_BEV1 + meeu_pkg::PC_STEP)
                                    : (meeu_pkg::VEC_GENERAL_BEV0 + meeu_pkg::PC_STEP);
            end
            meeu_pkg::KIND_ALIGN: begin
                if (addr_bad) begin
                    o_state.bad_address = i_event.access_address;
                end
                o_result.misaligned = addr_bad;
            end
            meeu_pkg::KIND_RESET: begin
                o_state.status    = meeu_pkg::STATUS_RESET;
                o_result.redirect = 1'b1;
                o_result.new_pc   = meeu_pkg::VEC_RESET;
                o_result.next_pc  = meeu_pkg::VEC_RESET + meeu_pkg::PC_STEP;
            end
            meeu_pkg::KIND_STATUS_WRITE: begin
                o_state.status = i_event.write_value;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

@@ rtl/mips_exception_entry_unit.sv @@
// Top level of the coprocessor-0 exception entry unit: input register, state, result register.
// Depends on meeu_pkg and meeu_core.
//
// Channel   Dir  Group        Contents
// events    in   s_axis       tuser: kind; tdata: exc_code .. write_value
// results   out  m_axis       tuser: redirect, misaligned; tdata: vectors and CP0 state
//
// An item is registered on acceptance and its result is registered when it moves on to the
// result register; one item per cycle is sustained while the output is not stalled.
// The status, EPC, cause and bad-address registers update when the result is registered.
// A stalled output holds its result; the input register still takes one more item.
// Reset (synchronous, active low) loads status 0x10900000, clears the other CP0 registers
// and empties both stages.
module mips_exception_entry_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: exc_code[4:0], current_pc[36:5], in_delay_slot[37], access_address[69:38],
    //        access_is_word[70], write_value[102:71], zero pad[103]
    input  logic [meeu_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [meeu_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: new_pc[31:0], next_pc[63:32], exception_pc[95:64], status_out[127:96],
    //        cause_code_out[132:128], branch_delay_out[133], bad_address_out[165:134],
    //        zero pad[167:166]
    output logic [meeu_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: redirect[0], misaligned[1]
    output logic [meeu_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    logic                 r_in_valid;
    meeu_pkg::t_event     r_in_event;
    meeu_pkg::t_event     n_in_event;
    meeu_pkg::t_cp0_state r_state;
    meeu_pkg::t_cp0_state n_state;
    logic                 r_out_valid;
    meeu_pkg::t_result    r_out_result;
    meeu_pkg::t_result    n_result;
    logic                 out_ready;
    logic                 step_fire;
    logic                 in_fire;

    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign step_fire       = r_in_valid && out_ready;
    assign o_s_axis_tready = !r_in_valid || out_ready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign n_in_event.kind           = meeu_pkg::t_kind'(i_s_axis_tuser[1:0]);
    assign n_in_event.exc_code       = i_s_axis_tdata[4:0];
    assign n_in_event.current_pc     = i_s_axis_tdata[36:5];
    assign n_in_event.in_delay_slot  = i_s_axis_tdata[37];
    assign n_in_event.access_address = i_s_axis_tdata[69:38];
    assign n_in_event.access_is_word = i_s_axis_tdata[70];
    assign n_in_event.write_value    = i_s_axis_tdata[102:71];

    meeu_core u_core (
        .i_event  (r_in_event),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.status      <= meeu_pkg::STATUS_RESET;
            r_state.epc         <= '0;
            r_state.cause       <= '0;
            r_state.bd          <= 1'b0;
            r_state.bad_address <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end
            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_event <= n_in_event;
        end
        if (step_fire) begin
            r_out_result <= n_result;
        end
    end

    // The state only changes together with the result register, so it matches the held result.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_out_result.misaligned, r_out_result.redirect};
    assign o_m_axis_tdata  = {2'b00, r_state.bad_address, r_state.bd, r_state.cause,
                              r_state.status, r_state.epc,
                              r_out_result.next_pc, r_out_result.new_pc};

    a_next_pc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out_result.redirect |->
            r_out_result.next_pc == r_out_result.new_pc + meeu_pkg::PC_STEP)
        else $error("next_pc does not follow new_pc");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_out_result.redirect && r_out_result.misaligned))
        else $error("redirect and misaligned both set");

    a_reset_status: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state.status == meeu_pkg::STATUS_RESET)
        else $error("status register not loaded by reset");

    a_reset_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && r_in_event.kind == meeu_pkg::KIND_RESET |=>
            r_out_result.new_pc == meeu_pkg::VEC_RESET &&
            r_state.status == meeu_pkg::STATUS_RESET)
        else $error("reset event did not select the reset vector");

    a_state_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step_fire |=> $stable(r_state))
        else $error("CP0 state changed without a step");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the coprocessor-0 exception entry unit.
// Drives event items into the stream input, predicts the CP0 state, and compares every result.
// Depends on meeu_pkg and mips_exception_entry_unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 200;

    typedef struct {
        logic        redirect;
        logic [31:0] new_pc;
        logic [31:0] next_pc;
        logic [31:0] exception_pc;
        logic [31:0] status_out;
        logic [4:0]  cause_code_out;
        logic        branch_delay_out;
        logic [31:0] bad_address_out;
        logic        misaligned;
    } t_cp0_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [meeu_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [meeu_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [meeu_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [meeu_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser;

    mips_exception_entry_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Events waiting to be sent and results waiting to arrive.
    meeu_pkg::t_event pending_events[$];
    t_cp0_result      expected_results[$];

    // Predicted CP0 state.
    logic [31:0] cp0_status = meeu_pkg::STATUS_RESET;
    logic [31:0] cp0_epc    = '0;
    logic [4:0]  cp0_cause  = '0;
    logic        cp0_bd     = 1'b0;
    logic [31:0] cp0_badvaddr = '0;

    int mismatches   = 0;
    int results_seen = 0;
    int misaligned_seen = 0;
    int cycles       = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    logic offer_taken = 1'b0;

    t_cp0_result      want_r, got_r;
    meeu_pkg::t_event taken_ev;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic predict_cp0(input meeu_pkg::t_event ev, output t_cp0_result r);
        logic [5:0] mode_stack;
        logic [1:0] align_mask;
        r = '{default: '0};
        case (ev.kind)
            meeu_pkg::KIND_EXCEPTION: begin
                // Push the mode/interrupt-enable stack by two bits.
                mode_stack = cp0_status[5:0];
                cp0_status[5:0] = {mode_stack[3:0], 2'b00};
                if (ev.in_delay_slot) begin
                    cp0_bd  = 1'b1;
                    cp0_epc = ev.current_pc - meeu_pkg::PC_STEP;
                end else begin
                    cp0_bd  = 1'b0;
                    cp0_epc = ev.current_pc;
                end
                cp0_cause  = ev.exc_code;
                r.new_pc   = cp0_status[meeu_pkg::BEV_BIT] ? meeu_pkg::VEC_GENERAL_BEV1
                                                           : meeu_pkg::VEC_GENERAL_BEV0;
                r.redirect = 1'b1;
            end
            meeu_pkg::KIND_ALIGN: begin
                align_mask = ev.access_is_word ? 2'b11 : 2'b01;
                if ((ev.access_address[1:0] & align_mask) != 2'b00) begin
                    cp0_badvaddr = ev.access_address;
                    r.misaligned = 1'b1;
                end
            end
            meeu_pkg::KIND_RESET: begin
                cp0_status = meeu_pkg::STATUS_RESET;
                r.new_pc   = meeu_pkg::VEC_RESET;
                r.redirect = 1'b1;
            end
            default: begin
                cp0_status = ev.write_value;
            end
        endcase
        r.next_pc          = r.redirect ? r.new_pc + meeu_pkg::PC_STEP : 32'd0;
        r.exception_pc     = cp0_epc;
        r.status_out       = cp0_status;
        r.cause_code_out   = cp0_cause;
        r.branch_delay_out = cp0_bd;
        r.bad_address_out  = cp0_badvaddr;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Every field random, then the caller overrides what the case needs.
    function automatic meeu_pkg::t_event make_event(input meeu_pkg::t_kind kind);
        meeu_pkg::t_event ev;
        ev.kind           = kind;
        ev.exc_code       = 5'($urandom);
        ev.current_pc     = pick_word();
        ev.in_delay_slot  = 1'($urandom);
        ev.access_address = pick_word();
        ev.access_is_word = 1'($urandom);
        ev.write_value    = pick_word();
        return ev;
    endfunction

    // Driver: bursts of random length with random gaps; holds an item until it is taken.
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !offer_taken) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            i_s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tuser  <= pending_events[0].kind;
            i_s_axis_tdata  <= {1'b0, pending_events[0].write_value,
                                pending_events[0].access_is_word,
                                pending_events[0].access_address,
                                pending_events[0].in_delay_slot,
                                pending_events[0].current_pc,
                                pending_events[0].exc_code};
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 30);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: a stall pattern that changes every so often, plus one long hold.
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    int   rx_hold_left = 0;
    logic rx_hold_done = 1'b0;
    logic rx_phase = 1'b0;

    always @(negedge i_clk) begin
        rx_phase = ~rx_phase;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!rx_hold_done && results_seen >= HOLD_AFTER) begin
            // The sender keeps offering items while the output is held off.
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 80);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_axis_tready <= rx_phase;
            endcase
        end
    end

    // Monitor: checks results, predicts accepted items, counts cycles.
    always @(posedge i_clk) begin
        offer_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;

        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            got_r.new_pc           = o_m_axis_tdata[31:0];
            got_r.next_pc          = o_m_axis_tdata[63:32];
            got_r.exception_pc     = o_m_axis_tdata[95:64];
            got_r.status_out       = o_m_axis_tdata[127:96];
            got_r.cause_code_out   = o_m_axis_tdata[132:128];
            got_r.branch_delay_out = o_m_axis_tdata[133];
            got_r.bad_address_out  = o_m_axis_tdata[165:134];
            got_r.redirect         = o_m_axis_tuser[0];
            got_r.misaligned       = o_m_axis_tuser[1];
            if (expected_results.size() == 0) begin
                $error("result item arrived with no event outstanding");
                mismatches++;
            end else begin
                want_r = expected_results.pop_front();
                if (want_r.misaligned) misaligned_seen++;
                compare_field("redirect", 32'(want_r.redirect), 32'(got_r.redirect));
                compare_field("new_pc", want_r.new_pc, got_r.new_pc);
                compare_field("next_pc", want_r.next_pc, got_r.next_pc);
                compare_field("exception_pc", want_r.exception_pc, got_r.exception_pc);
                compare_field("status_out", want_r.status_out, got_r.status_out);
                compare_field("cause_code_out", 32'(want_r.cause_code_out),
                              32'(got_r.cause_code_out));
                compare_field("branch_delay_out", 32'(want_r.branch_delay_out),
                              32'(got_r.branch_delay_out));
                compare_field("bad_address_out", want_r.bad_address_out,
                              got_r.bad_address_out);
                compare_field("misaligned", 32'(want_r.misaligned), 32'(got_r.misaligned));
            end
        end

        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            taken_ev = pending_events.pop_front();
            kind_seen[taken_ev.kind]++;
            predict_cp0(taken_ev, want_r);
            expected_results.push_back(want_r);
        end

        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_write(input logic [31:0] value);
        meeu_pkg::t_event ev;
        ev = make_event(meeu_pkg::KIND_STATUS_WRITE);
        ev.write_value = value;
        pending_events.push_back(ev);
    endtask

    task automatic queue_exception(input logic [31:0] pc, input logic slot,
                                   input logic [4:0] code);
        meeu_pkg::t_event ev;
        ev = make_event(meeu_pkg::KIND_EXCEPTION);
        ev.current_pc    = pc;
        ev.in_delay_slot = slot;
        ev.exc_code      = code;
        pending_events.push_back(ev);
    endtask

    task automatic queue_align(input logic [31:0] addr, input logic is_word);
        meeu_pkg::t_event ev;
        ev = make_event(meeu_pkg::KIND_ALIGN);
        ev.access_address = addr;
        ev.access_is_word = is_word;
        pending_events.push_back(ev);
    endtask

    initial begin
        int pick;
        meeu_pkg::t_event ev;

        // Directed: delay-slot wrap, both vectors, stack push, reset with BEV set,
        // aligned and misaligned accesses at both boundaries.
        queue_exception(32'h0000_0000, 1'b1, 5'd0);
        queue_exception(32'hFFFF_FFFF, 1'b0, 5'd31);
        queue_write(32'h0040_003F);
        queue_exception(32'h1234_5678, 1'b0, 5'd4);
        queue_exception(32'h8000_0004, 1'b1, 5'd5);
        queue_write(32'hFFFF_FFFF);
        queue_exception(32'h0000_0004, 1'b1, 5'd12);
        pending_events.push_back(make_event(meeu_pkg::KIND_RESET));
        queue_write(32'h0000_0000);
        queue_align(32'h0000_0000, 1'b1);
        queue_align(32'h0000_0001, 1'b1);
        queue_align(32'h0000_0002, 1'b1);
        queue_align(32'h0000_0003, 1'b1);
        queue_align(32'h0000_0001, 1'b0);
        queue_align(32'h0000_0002, 1'b0);
        queue_align(32'hFFFF_FFFF, 1'b1);
        queue_align(32'hFFFF_FFFE, 1'b0);
        queue_align(32'hFFFF_FFFC, 1'b1);
        queue_exception(32'hDEAD_BEEF, 1'b0, 5'd21);
        queue_write(32'h0040_0000);
        pending_events.push_back(make_event(meeu_pkg::KIND_RESET));
        queue_write(32'h0000_0015);
        queue_exception(32'h0000_0100, 1'b0, 5'd8);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      ev = make_event(meeu_pkg::KIND_EXCEPTION);
            else if (pick < 65) ev = make_event(meeu_pkg::KIND_ALIGN);
            else if (pick < 75) ev = make_event(meeu_pkg::KIND_RESET);
            else                ev = make_event(meeu_pkg::KIND_STATUS_WRITE);
            pending_events.push_back(ev);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_events.size() != 0) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("covered %0d exceptions, %0d alignment checks (%0d misaligned), %0d resets,",
                 kind_seen[meeu_pkg::KIND_EXCEPTION], kind_seen[meeu_pkg::KIND_ALIGN],
                 misaligned_seen, kind_seen[meeu_pkg::KIND_RESET]);
        $display("%0d status writes; %0d results checked with %0d field errors",
                 kind_seen[meeu_pkg::KIND_STATUS_WRITE], results_seen, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/meeu_pkg.sv
rtl/meeu_core.sv
rtl/mips_exception_entry_unit.sv
test/tb_top.sv
